>>> sv/u8d_pkg.sv
// Shared types and constants for the UTF-8 stream decoder.
`default_nettype none

package u8d_pkg;

    // Width of a decoded code point
    localparam int unsigned CP_W = 21;

    // Tag bits of a continuation byte
    localparam logic [1:0] CONT_TAG = 2'b10;

    // Lead byte tags for two, three and four byte sequences
    localparam logic [2:0] LEAD2_TAG = 3'b110;
    localparam logic [3:0] LEAD3_TAG = 4'b1110;
    localparam logic [4:0] LEAD4_TAG = 5'b11110;

    // Input request
    typedef struct packed {
        logic [7:0] byte_in;
        logic       buffer_end;
    } t_in;

    // Result request
    typedef struct packed {
        logic            result_kind;
        logic [CP_W-1:0] code_point;
        logic            run_last;
        logic            stream_done;
        logic            all_valid;
    } t_out;

    // Command from front to back: err_count errors, then an optional tail result
    typedef struct packed {
        logic [1:0]      err_count;
        logic            tail_v;
        logic            tail_err;
        logic [CP_W-1:0] cp;
        logic            done;
    } t_cmd;

    // Queue status seen by both sides
    typedef struct packed {
        logic empty;
        logic full;
    } t_qstat;

endpackage

`default_nettype wire

>>> sv/u8d_front.sv
// Front end: accepts bytes, tracks the pending sequence and issues commands.
`default_nettype none

module u8d_front (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire u8d_pkg::t_in    i_in,
    output logic                 o_stall,
    input  wire u8d_pkg::t_qstat i_qstat,
    output logic                 o_push,
    output u8d_pkg::t_cmd        o_cmd
);

    logic [1:0]               r_needed, n_needed;
    logic [1:0]               r_taken,  n_taken;
    logic [u8d_pkg::CP_W-1:0] r_pv,     n_pv;

    logic                     accept;
    logic                     fresh;
    logic [1:0]               need;
    logic [u8d_pkg::CP_W-1:0] val;
    logic [u8d_pkg::CP_W-1:0] pv_ext;
    logic [1:0]               taken_inc;
    logic [1:0]               needed_dec;
    logic [7:0]               b;
    logic                     e;

    assign o_stall = i_qstat.full;
    assign accept  = i_valid && !i_qstat.full;
    assign b       = i_in.byte_in;
    assign e       = i_in.buffer_end;

    assign pv_ext     = {r_pv[u8d_pkg::CP_W-7:0], b[5:0]};
    assign taken_inc  = r_taken + 2'd1;
    assign needed_dec = r_needed - 2'd1;

    // Classify the byte against the pending sequence
    always_comb begin
        n_needed        = r_needed;
        n_taken         = r_taken;
        n_pv            = r_pv;
        fresh           = 1'b1;
        need            = 2'd0;
        val             = '0;
        o_cmd.err_count = 2'd0;
        o_cmd.tail_v    = 1'b0;
        o_cmd.tail_err  = 1'b0;
        o_cmd.cp        = '0;
        o_cmd.done      = e;

        if (r_needed != 2'd0) begin
            if (b[7:6] == u8d_pkg::CONT_TAG) begin
                fresh = 1'b0;
                if (needed_dec == 2'd0) begin
                    o_cmd.tail_v = 1'b1;
                    o_cmd.cp     = pv_ext;
                    n_needed     = 2'd0;
                    n_taken      = 2'd0;
                    n_pv         = '0;
                end else if (e) begin
                    o_cmd.err_count = taken_inc + 2'd1;
                    n_needed        = 2'd0;
                    n_taken         = 2'd0;
                    n_pv            = '0;
                end else begin
                    n_needed = needed_dec;
                    n_taken  = taken_inc;
                    n_pv     = pv_ext;
                end
            end else begin
                // broken sequence: errors for lead and taken bytes
                o_cmd.err_count = r_taken + 2'd1;
                n_needed        = 2'd0;
                n_taken         = 2'd0;
                n_pv            = '0;
            end
        end

        if (fresh) begin
            if (!b[7]) begin
                o_cmd.tail_v = 1'b1;
                o_cmd.cp     = {{(u8d_pkg::CP_W-8){1'b0}}, b};
            end else if (b[7:5] == u8d_pkg::LEAD2_TAG) begin
                need = 2'd1;
                val  = {{(u8d_pkg::CP_W-5){1'b0}}, b[4:0]};
            end else if (b[7:4] == u8d_pkg::LEAD3_TAG) begin
                need = 2'd2;
                val  = {{(u8d_pkg::CP_W-4){1'b0}}, b[3:0]};
            end else if (b[7:3] == u8d_pkg::LEAD4_TAG) begin
                need = 2'd3;
                val  = {{(u8d_pkg::CP_W-3){1'b0}}, b[2:0]};
            end else begin
                o_cmd.tail_v   = 1'b1;
                o_cmd.tail_err = 1'b1;
            end
            if (need != 2'd0) begin
                if (e) begin
                    o_cmd.tail_v   = 1'b1;
                    o_cmd.tail_err = 1'b1;
                end else begin
                    n_needed = need;
                    n_taken  = 2'd0;
                    n_pv     = val;
                end
            end
        end

        // end of buffer drops any pending sequence
        if (e) begin
            n_needed = 2'd0;
            n_taken  = 2'd0;
            n_pv     = '0;
        end
    end

    assign o_push = accept && ((o_cmd.err_count != 2'd0) || o_cmd.tail_v);

    // Sequence state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_needed <= 2'd0;
            r_taken  <= 2'd0;
            r_pv     <= '0;
        end else if (accept) begin
            r_needed <= n_needed;
            r_taken  <= n_taken;
            r_pv     <= n_pv;
        end
    end

`ifndef NO_ASSERTIONS
    a_taken_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_needed == 2'd0) |-> (r_taken == 2'd0))
        else $error("taken count set with no pending sequence");
    a_seq_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ({1'b0, r_needed} + {1'b0, r_taken}) <= 3'd3)
        else $error("pending sequence longer than four bytes");
    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_qstat.full)
        else $error("push into full queue");
`endif

endmodule

`default_nettype wire

>>> sv/u8d_queue.sv
// Short command queue between the front and back ends.
`default_nettype none

module u8d_queue #(
    parameter int unsigned DEPTH = 4
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_push,
    input  wire u8d_pkg::t_cmd i_cmd,
    input  wire logic          i_pop,
    output u8d_pkg::t_cmd      o_head,
    output u8d_pkg::t_qstat    o_stat
);

    localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);

    u8d_pkg::t_cmd r_mem [DEPTH];
    logic [PW-1:0] r_wr, r_rd;
    logic [CW-1:0] r_count;

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_head       = r_mem[r_rd];

    // Storage
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    // Pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == PW'(DEPTH - 1)) ? '0 : r_wr + PW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == PW'(DEPTH - 1)) ? '0 : r_rd + PW'(1);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CW'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CW'(1);
            end
        end
    end

`ifndef NO_ASSERTIONS
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(DEPTH))
        else $error("queue count beyond depth");
    a_pop_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("pop from empty queue");
    a_ptr_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stat.empty |-> (r_wr == r_rd))
        else $error("pointers differ on empty queue");
`endif

endmodule

`default_nettype wire

>>> sv/u8d_back.sv
// Back end: expands commands into result requests and tracks the all-valid flag.
`default_nettype none

module u8d_back (
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire u8d_pkg::t_qstat i_qstat,
    input  wire u8d_pkg::t_cmd   i_head,
    output logic                 o_pop,
    output logic                 o_valid,
    output u8d_pkg::t_out        o_out,
    input  wire logic            i_stall
);

    logic          r_valid;
    u8d_pkg::t_out r_out, n_out;
    logic [1:0]    r_idx;
    logic          r_allv;

    logic          adv;
    logic          go;
    logic          err_phase;
    logic          last;

    assign adv = !r_valid || !i_stall;
    assign go  = adv && !i_qstat.empty;

    // Next result of the head command
    always_comb begin
        err_phase         = (r_idx < i_head.err_count);
        last              = err_phase ? ((r_idx == i_head.err_count - 2'd1) && !i_head.tail_v)
                                      : 1'b1;
        n_out.result_kind = err_phase ? 1'b1 : i_head.tail_err;
        n_out.code_point  = n_out.result_kind ? '0 : i_head.cp;
        n_out.run_last    = last;
        n_out.stream_done = i_head.done;
        n_out.all_valid   = n_out.result_kind ? 1'b0 : r_allv;
    end

    assign o_pop   = go && last;
    assign o_valid = r_valid;
    assign o_out   = r_out;

    // Output register, result index and all-valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 2'd0;
            r_allv  <= 1'b1;
        end else if (go) begin
            r_valid <= 1'b1;
            r_out   <= n_out;
            r_idx   <= last ? 2'd0 : r_idx + 2'd1;
            r_allv  <= (last && i_head.done) ? 1'b1 : n_out.all_valid;
        end else if (adv) begin
            r_valid <= 1'b0;
        end
    end

`ifndef NO_ASSERTIONS
    a_idx_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !i_qstat.empty |-> (r_idx <= i_head.err_count))
        else $error("result index past error count");
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && r_out.result_kind) |-> (r_out.code_point == '0 && !r_out.all_valid))
        else $error("error result with code point or valid flag");
    a_idx_rest: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_qstat.empty |-> (r_idx == 2'd0))
        else $error("result index left set with nothing queued");
`endif

endmodule

`default_nettype wire

>>> sv/utf8_stream_decoder.sv
// Top level of the UTF-8 stream decoder: front end, command queue and back end.
//
//  Channel | Direction | Handshake           | Payload
//  input   | in        | i_valid / o_stall   | i_in  (u8d_pkg::t_in)
//  output  | out       | o_valid / i_stall   | o_out (u8d_pkg::t_out)
//
//  One byte is taken per cycle while the queue has room; results leave at one per cycle
//  unless the receiver stalls. A byte gives up to four results, sent one at a time, so
//  error bursts fill the QUEUE_DEPTH-entry command queue and stall the input briefly.
//  Each command goes through the queue memory, then the back end's output register.
//  Reset is synchronous, active low, and clears sequence state, queue and output valid.
`default_nettype none

module utf8_stream_decoder #(
    parameter int unsigned QUEUE_DEPTH = 4
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_valid,
    input  wire u8d_pkg::t_in i_in,
    output logic              o_stall,
    output logic              o_valid,
    output u8d_pkg::t_out     o_out,
    input  wire logic         i_stall
);

    u8d_pkg::t_cmd   push_cmd;
    u8d_pkg::t_cmd   head_cmd;
    u8d_pkg::t_qstat qstat;
    logic            push;
    logic            pop;

    u8d_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_in    (i_in),
        .o_stall (o_stall),
        .i_qstat (qstat),
        .o_push  (push),
        .o_cmd   (push_cmd)
    );

    u8d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_head  (head_cmd),
        .o_stat  (qstat)
    );

    u8d_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_qstat (qstat),
        .i_head  (head_cmd),
        .o_pop   (pop),
        .o_valid (o_valid),
        .o_out   (o_out),
        .i_stall (i_stall)
    );

endmodule

`default_nettype wire

>>> test/utf8_stream_decoder_test.sv
// Self-checking testbench for the UTF-8 stream decoder with random idling on both sides.
`timescale 1ns / 100ps

module utf8_stream_decoder_test;

    // Result kinds
    localparam logic KIND_CP  = 1'b0;
    localparam logic KIND_ERR = 1'b1;

    // Cycles without any accepted request before the run is abandoned
    localparam int QUIET_LIMIT = 1000;
    localparam int RANDOM_BYTES = 350;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_valid = 1'b0;
    u8d_pkg::t_in  i_in = '0;
    logic          o_stall;
    logic          o_valid;
    u8d_pkg::t_out o_out;
    logic          i_stall = 1'b0;

    utf8_stream_decoder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_in    (i_in),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_out   (o_out),
        .i_stall (i_stall)
    );

    always #5 i_clk = ~i_clk;

    // Bytes waiting to be sent, and decoded results waiting to come out
    u8d_pkg::t_in  byte_q[$];
    u8d_pkg::t_out decoded_q[$];

    // Decoder state mirrored from the spec
    logic [1:0]               cont_left = '0;
    logic [1:0]               cont_seen = '0;
    logic [u8d_pkg::CP_W-1:0] cp_acc    = '0;
    logic                     buf_ok    = 1'b1;

    int  mismatches   = 0;
    int  quiet_cycles = 0;
    bit  in_taken     = 1'b0;
    int  send_gap     = 0;
    int  stall_left   = 0;
    bit  send_calm    = 1'b0;
    bit  recv_calm    = 1'b0;

    // ---------------------------------------------------------------
    // Decoding predictor
    // ---------------------------------------------------------------

    function automatic void add_result(input logic kind,
                                       input logic [u8d_pkg::CP_W-1:0] cp,
                                       input logic done);
        u8d_pkg::t_out r;
        if (kind == KIND_ERR)
            buf_ok = 1'b0;
        r.result_kind = kind;
        r.code_point  = (kind == KIND_ERR) ? '0 : cp;
        r.run_last    = 1'b0;
        r.stream_done = done;
        r.all_valid   = buf_ok;
        decoded_q.push_back(r);
    endfunction

    // Lead byte plus every continuation already taken
    function automatic void add_seq_errors(input logic done);
        for (int i = 0; i <= int'(cont_seen); i++)
            add_result(KIND_ERR, '0, done);
    endfunction

    function automatic void drop_seq();
        cont_left = '0;
        cont_seen = '0;
        cp_acc    = '0;
    endfunction

    function automatic void decode_byte(input u8d_pkg::t_in req);
        logic [7:0]               b;
        logic                     e;
        logic [1:0]               need;
        logic [u8d_pkg::CP_W-1:0] val;
        bit                       fresh;
        int                       n0;
        b     = req.byte_in;
        e     = req.buffer_end;
        need  = '0;
        val   = '0;
        fresh = 1'b1;
        n0    = decoded_q.size();

        // Pending sequence: take a continuation or give up on it
        if (cont_left != 0) begin
            if (b[7:6] == u8d_pkg::CONT_TAG) begin
                fresh     = 1'b0;
                cp_acc    = {cp_acc[u8d_pkg::CP_W-7:0], b[5:0]};
                cont_seen = cont_seen + 2'd1;
                cont_left = cont_left - 2'd1;
                if (cont_left == 0) begin
                    add_result(KIND_CP, cp_acc, e);
                    drop_seq();
                end else if (e) begin
                    add_seq_errors(e);
                    drop_seq();
                end
            end else begin
                add_seq_errors(e);
                drop_seq();
            end
        end

        // Byte starts afresh, including the one that broke a sequence
        if (fresh) begin
            if (b[7] == 1'b0) begin
                add_result(KIND_CP, u8d_pkg::CP_W'(b), e);
            end else if (b[7:5] == u8d_pkg::LEAD2_TAG) begin
                need = 2'd1;
                val  = u8d_pkg::CP_W'(b[4:0]);
            end else if (b[7:4] == u8d_pkg::LEAD3_TAG) begin
                need = 2'd2;
                val  = u8d_pkg::CP_W'(b[3:0]);
            end else if (b[7:3] == u8d_pkg::LEAD4_TAG) begin
                need = 2'd3;
                val  = u8d_pkg::CP_W'(b[2:0]);
            end else begin
                add_result(KIND_ERR, '0, e);
            end
            if (need != 0) begin
                if (e) begin
                    add_result(KIND_ERR, '0, e);
                end else begin
                    cont_left = need;
                    cont_seen = '0;
                    cp_acc    = val;
                end
            end
        end

        if (decoded_q.size() > n0)
            decoded_q[$].run_last = 1'b1;

        // End of buffer returns everything to its reset value
        if (e) begin
            drop_seq();
            buf_ok = 1'b1;
        end
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------

    function automatic void push_byte(input logic [7:0] b, input logic e);
        u8d_pkg::t_in r;
        r.byte_in    = b;
        r.buffer_end = e;
        byte_q.push_back(r);
    endfunction

    function automatic logic [7:0] lead_byte(input int len);
        case (len)
            1:       return {1'b0, 7'($urandom)};
            2:       return {u8d_pkg::LEAD2_TAG, 5'($urandom)};
            3:       return {u8d_pkg::LEAD3_TAG, 4'($urandom)};
            default: return {u8d_pkg::LEAD4_TAG, 3'($urandom)};
        endcase
    endfunction

    function automatic logic [7:0] cont_byte();
        return {u8d_pkg::CONT_TAG, 6'($urandom)};
    endfunction

    function automatic logic buffer_ends();
        return ($urandom_range(0, 9) == 0);
    endfunction

    // Mostly short gaps, now and then a long one
    function automatic int idle_len(input bit calm);
        int r;
        if (calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 90)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // ---------------------------------------------------------------
    // Sampling at the rising edge: predictor, result check, watchdog
    // ---------------------------------------------------------------

    always @(posedge i_clk) begin
        u8d_pkg::t_out want;
        if (i_rst_n) begin
            in_taken <= i_valid && !o_stall;
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;

            if (o_valid && !i_stall) begin
                if (decoded_q.size() == 0) begin
                    $error("result with none expected: kind %0d cp %h", o_out.result_kind,
                           o_out.code_point);
                    mismatches++;
                end else begin
                    want = decoded_q.pop_front();
                    if (o_out.result_kind !== want.result_kind) begin
                        $error("result_kind: expected %0d, got %0d", want.result_kind,
                               o_out.result_kind);
                        mismatches++;
                    end
                    if (o_out.code_point !== want.code_point) begin
                        $error("code_point: expected %h, got %h", want.code_point,
                               o_out.code_point);
                        mismatches++;
                    end
                    if (o_out.run_last !== want.run_last) begin
                        $error("run_last: expected %0d, got %0d", want.run_last,
                               o_out.run_last);
                        mismatches++;
                    end
                    if (o_out.stream_done !== want.stream_done) begin
                        $error("stream_done: expected %0d, got %0d", want.stream_done,
                               o_out.stream_done);
                        mismatches++;
                    end
                    if (o_out.all_valid !== want.all_valid) begin
                        $error("all_valid: expected %0d, got %0d", want.all_valid,
                               o_out.all_valid);
                        mismatches++;
                    end
                end
            end

            if (i_valid && !o_stall)
                decode_byte(i_in);
        end
    end

    // ---------------------------------------------------------------
    // Request driver, changes inputs at the falling edge
    // ---------------------------------------------------------------

    always @(negedge i_clk) begin
        logic         nv;
        u8d_pkg::t_in nd;
        nv = i_valid;
        nd = i_in;
        if (i_rst_n) begin
            if (in_taken)
                nv = 1'b0;
            if (!nv) begin
                if (send_gap > 0) begin
                    send_gap--;
                end else if (byte_q.size() != 0) begin
                    nd = byte_q.pop_front();
                    nv = 1'b1;
                    if ($urandom_range(0, 39) == 0)
                        send_calm = !send_calm;
                    send_gap = idle_len(send_calm);
                end
            end
        end
        i_valid <= nv;
        i_in    <= nd;
    end

    // Receiver back-pressure
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
        end else if (stall_left > 0) begin
            i_stall <= 1'b1;
            stall_left--;
        end else begin
            i_stall <= 1'b0;
            if ($urandom_range(0, 39) == 0)
                recv_calm = !recv_calm;
            stall_left = idle_len(recv_calm);
        end
    end

    // Watchdog
    initial begin
        wait (quiet_cycles >= QUIET_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    // ---------------------------------------------------------------
    // Stimulus and end of run
    // ---------------------------------------------------------------

    initial begin
        int         pick;
        int         len;
        int         k;
        bit         cut;
        logic [7:0] b;

        // Directed: field extremes, overlong, surrogate, largest value
        push_byte(8'h00, 1'b0);
        push_byte(8'h7F, 1'b0);
        push_byte(8'hC0, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'hAC, 1'b0);
        push_byte(8'hED, 1'b0);
        push_byte(8'hA0, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'hF7, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b0);
        push_byte(8'hBF, 1'b1);
        // Stray continuation and bad leads
        push_byte(8'h80, 1'b0);
        push_byte(8'hFF, 1'b0);
        push_byte(8'hF8, 1'b0);
        // Broken sequences, the second one giving four results
        push_byte(8'hE2, 1'b0);
        push_byte(8'h82, 1'b0);
        push_byte(8'h41, 1'b0);
        push_byte(8'hF0, 1'b0);
        push_byte(8'h90, 1'b0);
        push_byte(8'h80, 1'b0);
        push_byte(8'h41, 1'b0);
        // Cut off by end of buffer, then a lead that is itself the final byte
        push_byte(8'hF0, 1'b0);
        push_byte(8'h90, 1'b1);
        push_byte(8'hC3, 1'b1);

        // Random: mostly well-formed sequences, some broken, cut off or noise
        while (byte_q.size() < 27 + RANDOM_BYTES) begin
            pick = $urandom_range(0, 99);
            if (pick < 75) begin
                len = $urandom_range(1, 4);
                push_byte(lead_byte(len), (len == 1) && buffer_ends());
                for (k = 1; k < len; k++)
                    push_byte(cont_byte(), (k == len - 1) && buffer_ends());
            end else if (pick < 92) begin
                len = $urandom_range(2, 4);
                k   = $urandom_range(0, len - 2);
                cut = (pick >= 85);
                push_byte(lead_byte(len), cut && (k == 0));
                for (int i = 1; i <= k; i++)
                    push_byte(cont_byte(), cut && (i == k));
                if (!cut) begin
                    do
                        b = 8'($urandom);
                    while (b[7:6] == u8d_pkg::CONT_TAG);
                    push_byte(b, buffer_ends());
                end
            end else begin
                push_byte(8'($urandom), buffer_ends());
            end
        end

        // Reset
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Wait for every request to go in and every result to come out
        while (byte_q.size() != 0 || i_valid)
            @(negedge i_clk);
        while (decoded_q.size() != 0)
            @(negedge i_clk);
        repeat (20) @(negedge i_clk);

        if (mismatches == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule

>>> utf8_stream_decoder.f
sv/u8d_pkg.sv
sv/u8d_front.sv
sv/u8d_queue.sv
sv/u8d_back.sv
sv/utf8_stream_decoder.sv
test/utf8_stream_decoder_test.sv
